// File: hw/rtl/rud_pkg.sv
// Shared types, widths and register codes for the radial undistortion point map.
package rud_pkg;

   // Field widths
   localparam int PixW     = 12;  // integer pixel index
   localparam int PixFracW = 8;   // fraction bits of a Q12.8 coordinate
   localparam int CoordW   = 20;  // Q12.8 coordinate, focal length, center
   localparam int CoefW    = 24;  // Q4.20 radial coefficient
   localparam int FracW    = 20;  // fraction bits of Q.20 values
   localparam int NormW    = 24;  // saturated normalized coordinate, Q3.20
   localparam int DivSteps = NormW;  // quotient bits resolved by the divider
   localparam int PowW     = 30;  // saturated r4 and r6
   localparam int ScaledLimLog2 = 40;  // scaled point saturates at +/- 2^40

   // Image defaults
   localparam int ImgWidthDefault  = 640;
   localparam int ImgHeightDefault = 480;

   // Configuration port
   localparam int CsrAddrW = 5;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   localparam logic [CsrIdxW-1:0] RegFocalX  = 3'd0;
   localparam logic [CsrIdxW-1:0] RegFocalY  = 3'd1;
   localparam logic [CsrIdxW-1:0] RegCenterX = 3'd2;
   localparam logic [CsrIdxW-1:0] RegCenterY = 3'd3;
   localparam logic [CsrIdxW-1:0] RegRadialK1 = 3'd4;
   localparam logic [CsrIdxW-1:0] RegRadialK2 = 3'd5;
   localparam logic [CsrIdxW-1:0] RegRadialK3 = 3'd6;

   // Register reset values
   localparam logic [CoordW-1:0] FocalReset   = 20'd131072;
   localparam logic [CoordW-1:0] CenterXReset = 20'd81920;
   localparam logic [CoordW-1:0] CenterYReset = 20'd61440;

   // Request and response payloads
   typedef struct packed {
      logic [PixW-1:0] pixel_col;
      logic [PixW-1:0] pixel_row;
   } rud_req_type;

   typedef struct packed {
      logic [CoordW-1:0] source_col;
      logic [CoordW-1:0] source_row;
   } rud_rsp_type;

endpackage

// File: hw/rtl/radial_undistortion_point_map.sv
// Top level: maps an output pixel to its source coordinate under radial lens distortion.
//
//   channel   ports                              direction  handshake
//   request   start, busy, req_data              in         start && !busy
//   response  rsp_valid, rsp_data                out        one-cycle strobe
//   config    psel, penable, pwrite, paddr,      in/out     APB, pready tied high
//             pwdata, prdata, pready
//
// One transaction enters every cycle; busy stays low. Each result passes
// through one offset stage, the 24-step normalizing divider plus its entry
// and exit registers, then twelve arithmetic stages.
// Synchronous reset clears the valid pipeline and the configuration registers.
// The receiver cannot stall, so the pipeline never holds.
module radial_undistortion_point_map import rud_pkg::*; #(
   parameter int IMG_WIDTH  = ImgWidthDefault,
   parameter int IMG_HEIGHT = ImgHeightDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rud_req_type          req_data,
   output logic                 rsp_valid,
   output rud_rsp_type          rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CsrAddrW-1:0]  paddr,
   input  logic [CsrDataW-1:0]  pwdata,
   output logic [CsrDataW-1:0]  prdata,
   output logic                 pready
);

   localparam int NumAxes    = 2;
   localparam int AxisX      = 0;
   localparam int AxisY      = 1;
   localparam int TailStages = 12;
   localparam int Latency    = 1 + (DivSteps + 2) + TailStages;
   localparam int NDelay     = 8;

   localparam int SqW    = 2*NormW - 1;
   localparam int R2W    = SqW + 1 - FracW;
   localparam int R2sqW  = 2*R2W;
   localparam int R4r2W  = PowW + R2W;
   localparam int KpW    = CoefW + PowW + 1;
   localparam int SumW   = KpW + 2;
   localparam int GainW  = SumW - FracW + 1;
   localparam int GainHiW = GainW - FracW;
   localparam int HiW    = NormW + GainHiW;
   localparam int LoW    = NormW + FracW + 1;
   localparam int SW     = HiW + 1;
   localparam int SClW   = SW - 1;
   localparam int SHiW   = SClW - FracW;
   localparam int PhW    = SHiW + CoordW + 1;
   localparam int PlW    = FracW + CoordW;
   localparam int PW     = PhW + 2;

   localparam logic [PowW-1:0] PowMax = {PowW{1'b1}};
   localparam logic signed [GainW-1:0] GainOne = GainW'(1) <<< FracW;
   localparam logic signed [SW-1:0] SLimPos = SW'(1) <<< ScaledLimLog2;
   localparam logic signed [SW-1:0] SLimNeg = -SLimPos;
   localparam logic [CoordW-1:0] ColMax = CoordW'((IMG_WIDTH - 1) * (1 << PixFracW));
   localparam logic [CoordW-1:0] RowMax = CoordW'((IMG_HEIGHT - 1) * (1 << PixFracW));

   // Configuration registers
   logic [CoordW-1:0] focal_x_ff, focal_y_ff, ctr_col_ff, ctr_row_ff;
   logic [CoefW-1:0]  radial_k1_ff, radial_k2_ff, radial_k3_ff;
   logic              csr_write;
   logic [CsrIdxW-1:0] csr_index;

   logic accept;
   logic [Latency-1:0] vld_ff;

   // Per-axis views of the configuration
   logic [PixW-1:0]   pix       [NumAxes];
   logic [CoordW-1:0] focal_eff [NumAxes];
   logic [CoordW-1:0] center    [NumAxes];
   logic [CoordW-1:0] lim_max   [NumAxes];

   // Offset stage
   logic signed [CoordW:0] ofs [NumAxes];
   logic [CoordW-1:0] mag_in  [NumAxes];
   logic              neg_in  [NumAxes];
   logic [CoordW-1:0] mag_ff  [NumAxes];
   logic              neg_ff  [NumAxes];
   logic signed [NormW-1:0] norm [NumAxes];

   // Radius powers and gain
   logic signed [2*NormW-1:0] sq_full [NumAxes];
   logic [SqW-1:0]    sq_ff [NumAxes];
   logic [SqW:0]      r2_sum;
   logic [R2W-1:0]    r2_ff, r2_p3_ff, r2_p4_ff;
   logic [R2sqW-1:0]  r2sq_in, r2sq_ff;
   logic [PowW-1:0]   r4_in, r4_ff;
   logic [R4r2W-1:0]  r4r2_in, r4r2_ff;
   logic [PowW-1:0]   r6_in, r6_ff;
   logic signed [KpW-1:0]  kp1_in, kp1_ff, kp2_in, kp2_ff, kp3_in, kp3_ff;
   logic signed [SumW-1:0] part_in, part_ff, part_p7_ff, sum_full;
   logic signed [GainW-1:0] gain_in, gain_ff;
   logic signed [GainHiW-1:0] gain_hi;
   logic signed [FracW:0]     gain_lo;
   logic signed [NormW-1:0] n_dly_ff [NumAxes][NDelay];

   // Scale and map back
   logic signed [HiW-1:0] hi_in [NumAxes];
   logic signed [HiW-1:0] hi_ff [NumAxes];
   logic signed [LoW-1:0] lo_in [NumAxes];
   logic signed [LoW-1:0] lo_ff [NumAxes];
   logic signed [LoW-1:0] lo_sh [NumAxes];
   logic signed [SW-1:0]  s_full [NumAxes];
   logic signed [SW-1:0]  s_cl   [NumAxes];
   logic signed [SClW-1:0] s_ff  [NumAxes];
   logic signed [SHiW-1:0] s_hi  [NumAxes];
   logic signed [PhW-1:0] ph_in [NumAxes];
   logic signed [PhW-1:0] ph_ff [NumAxes];
   logic [PlW-1:0]        pl_in [NumAxes];
   logic [PlW-1:0]        pl_ff [NumAxes];
   logic signed [PW-1:0]  p_full [NumAxes];
   logic [CoordW-1:0]     out_in [NumAxes];
   logic [CoordW-1:0]     out_ff [NumAxes];

   // Handshakes
   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[CsrAddrW-1:2];

   // Write configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= FocalReset;
         focal_y_ff   <= FocalReset;
         ctr_col_ff   <= CenterXReset;
         ctr_row_ff   <= CenterYReset;
         radial_k1_ff <= '0;
         radial_k2_ff <= '0;
         radial_k3_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            RegFocalX:   focal_x_ff   <= pwdata[CoordW-1:0];
            RegFocalY:   focal_y_ff   <= pwdata[CoordW-1:0];
            RegCenterX:  ctr_col_ff   <= pwdata[CoordW-1:0];
            RegCenterY:  ctr_row_ff   <= pwdata[CoordW-1:0];
            RegRadialK1: radial_k1_ff <= pwdata[CoefW-1:0];
            RegRadialK2: radial_k2_ff <= pwdata[CoefW-1:0];
            RegRadialK3: radial_k3_ff <= pwdata[CoefW-1:0];
            default: ;
         endcase
      end
   end

   // Read back configuration registers
   always_comb begin
      unique case (csr_index)
         RegFocalX:   prdata = CsrDataW'(focal_x_ff);
         RegFocalY:   prdata = CsrDataW'(focal_y_ff);
         RegCenterX:  prdata = CsrDataW'(ctr_col_ff);
         RegCenterY:  prdata = CsrDataW'(ctr_row_ff);
         RegRadialK1: prdata = CsrDataW'(radial_k1_ff);
         RegRadialK2: prdata = CsrDataW'(radial_k2_ff);
         RegRadialK3: prdata = CsrDataW'(radial_k3_ff);
         default:     prdata = '0;
      endcase
   end

   // Gather per-axis operands; a zero focal length acts as one LSB
   always_comb begin
      pix[AxisX]       = req_data.pixel_col;
      pix[AxisY]       = req_data.pixel_row;
      focal_eff[AxisX] = (focal_x_ff == '0) ? CoordW'(1) : focal_x_ff;
      focal_eff[AxisY] = (focal_y_ff == '0) ? CoordW'(1) : focal_y_ff;
      center[AxisX]    = ctr_col_ff;
      center[AxisY]    = ctr_row_ff;
      lim_max[AxisX]   = ColMax;
      lim_max[AxisY]   = RowMax;
   end

   // Offset from the optical center, split into magnitude and sign
   always_comb begin
      for (int a = 0; a < NumAxes; a++) begin
         ofs[a]    = $signed({1'b0, pix[a], PixFracW'(0)}) - $signed({1'b0, center[a]});
         neg_in[a] = ofs[a][CoordW];
         mag_in[a] = neg_in[a] ? CoordW'(-ofs[a]) : CoordW'(ofs[a]);
      end
   end

   // Normalize each axis by its focal length
   for (genvar a = 0; a < NumAxes; a++) begin : g_div
      rud_norm_div u_div (
         .clock    (clock),
         .dist_mag (mag_ff[a]),
         .dist_neg (neg_ff[a]),
         .focal    (focal_eff[a]),
         .norm     (norm[a])
      );
   end

   // Radius powers, saturated
   always_comb begin
      for (int a = 0; a < NumAxes; a++) begin
         sq_full[a] = norm[a] * norm[a];
      end
      r2_sum  = {1'b0, sq_ff[AxisX]} + {1'b0, sq_ff[AxisY]};
      r2sq_in = r2_ff * r2_ff;
      if (r2sq_ff[R2sqW-1:FracW+PowW] != '0) begin
         r4_in = PowMax;
      end else begin
         r4_in = r2sq_ff[FracW+PowW-1:FracW];
      end
      r4r2_in = r4_ff * r2_p4_ff;
      if (r4r2_ff[R4r2W-1:FracW+PowW] != '0) begin
         r6_in = PowMax;
      end else begin
         r6_in = r4r2_ff[FracW+PowW-1:FracW];
      end
   end

   // Polynomial gain 1 + k1 r2 + k2 r4 + k3 r6
   always_comb begin
      kp1_in   = $signed(radial_k1_ff) * $signed({1'b0, r2_p4_ff});
      kp2_in   = $signed(radial_k2_ff) * $signed({1'b0, r4_ff});
      part_in  = kp1_ff + kp2_ff;
      kp3_in   = $signed(radial_k3_ff) * $signed({1'b0, r6_ff});
      sum_full = part_p7_ff + kp3_ff;
      gain_in  = $signed(sum_full[SumW-1:FracW]) + GainOne;
      gain_hi  = $signed(gain_ff[GainW-1:FracW]);
      gain_lo  = $signed({1'b0, gain_ff[FracW-1:0]});
   end

   // Scale the normalized point, map back to pixels and clamp to the image
   always_comb begin
      for (int a = 0; a < NumAxes; a++) begin
         hi_in[a]  = n_dly_ff[a][NDelay-1] * gain_hi;
         lo_in[a]  = n_dly_ff[a][NDelay-1] * gain_lo;
         lo_sh[a]  = lo_ff[a] >>> FracW;
         s_full[a] = SW'(hi_ff[a]) + $signed(lo_sh[a][SW-1:0]);
         if (s_full[a] > SLimPos) begin
            s_cl[a] = SLimPos;
         end else if (s_full[a] < SLimNeg) begin
            s_cl[a] = SLimNeg;
         end else begin
            s_cl[a] = s_full[a];
         end
         s_hi[a]   = $signed(s_ff[a][SClW-1:FracW]);
         ph_in[a]  = s_hi[a] * $signed({1'b0, focal_eff[a]});
         pl_in[a]  = s_ff[a][FracW-1:0] * focal_eff[a];
         p_full[a] = PW'(ph_ff[a]) + $signed(PW'(pl_ff[a] >> FracW))
                   + $signed(PW'(center[a]));
         if (p_full[a] < 0) begin
            out_in[a] = '0;
         end else if (p_full[a] > $signed(PW'(lim_max[a]))) begin
            out_in[a] = lim_max[a];
         end else begin
            out_in[a] = p_full[a][CoordW-1:0];
         end
      end
   end

   // Advance the valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Latency-2:0], accept};
      end
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      for (int a = 0; a < NumAxes; a++) begin
         mag_ff[a] <= mag_in[a];
         neg_ff[a] <= neg_in[a];
         sq_ff[a]  <= sq_full[a][SqW-1:0];
         n_dly_ff[a][0] <= norm[a];
         for (int k = 1; k < NDelay; k++) begin
            n_dly_ff[a][k] <= n_dly_ff[a][k-1];
         end
         hi_ff[a]  <= hi_in[a];
         lo_ff[a]  <= lo_in[a];
         s_ff[a]   <= $signed(s_cl[a][SClW-1:0]);
         ph_ff[a]  <= ph_in[a];
         pl_ff[a]  <= pl_in[a];
         out_ff[a] <= out_in[a];
      end
      r2_ff      <= r2_sum[SqW:FracW];
      r2sq_ff    <= r2sq_in;
      r2_p3_ff   <= r2_ff;
      r4_ff      <= r4_in;
      r2_p4_ff   <= r2_p3_ff;
      r4r2_ff    <= r4r2_in;
      kp1_ff     <= kp1_in;
      kp2_ff     <= kp2_in;
      r6_ff      <= r6_in;
      part_ff    <= part_in;
      kp3_ff     <= kp3_in;
      part_p7_ff <= part_ff;
      gain_ff    <= gain_in;
   end

   assign rsp_valid           = vld_ff[Latency-1];
   assign rsp_data.source_col = out_ff[AxisX];
   assign rsp_data.source_row = out_ff[AxisY];

   // Every result traces back to an accepted transaction
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, Latency))
      else $error("response without matching request");

   // Results stay inside the image
   a_col_in_image: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.source_col <= ColMax))
      else $error("source column beyond image");

   a_row_in_image: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.source_row <= RowMax))
      else $error("source row beyond image");

endmodule

// File: hw/rtl/rud_norm_div.sv
// Pipelined restoring divider that normalizes one center offset by a focal length.
module rud_norm_div import rud_pkg::*; (
   input  logic                     clock,
   input  logic [CoordW-1:0]        dist_mag,
   input  logic                     dist_neg,
   input  logic [CoordW-1:0]        focal,
   output logic signed [NormW-1:0]  norm
);

   // Dividend is dist_mag << FracW; its top bits seed the remainder.
   localparam int LowBits = DivSteps - FracW;

   localparam logic [NormW-1:0] NormPosMax = {1'b0, {(NormW-1){1'b1}}};
   localparam logic [NormW-1:0] NormNegMin = {1'b1, {(NormW-1){1'b0}}};

   typedef struct packed {
      logic [CoordW-1:0]   rem;
      logic [DivSteps-1:0] quo;
      logic [DivSteps-1:0] dvd;
      logic                neg;
      logic                ovf;
   } div_stage_type;

   div_stage_type stage_ff [DivSteps+1];
   div_stage_type step_in  [DivSteps];
   div_stage_type entry_in;
   logic [NormW-1:0] norm_in;
   logic [NormW-1:0] norm_ff;

   // One quotient bit: shift in the next dividend bit, subtract if it fits
   function automatic div_stage_type div_step(input div_stage_type cur,
                                              input logic [CoordW-1:0] dvs);
      logic [CoordW:0] partial;
      logic [CoordW:0] diff;
      logic            fits;
      div_stage_type   nxt;
      begin
         partial = {cur.rem, cur.dvd[DivSteps-1]};
         diff    = partial - {1'b0, dvs};
         fits    = (partial >= {1'b0, dvs});
         nxt     = cur;
         nxt.rem = fits ? diff[CoordW-1:0] : partial[CoordW-1:0];
         nxt.quo = {cur.quo[DivSteps-2:0], fits};
         nxt.dvd = {cur.dvd[DivSteps-2:0], 1'b0};
         return nxt;
      end
   endfunction

   // Seed the remainder and flag quotients too large for the result
   always_comb begin
      entry_in.rem = dist_mag >> LowBits;
      entry_in.quo = '0;
      entry_in.dvd = {dist_mag[LowBits-1:0], FracW'(0)};
      entry_in.neg = dist_neg;
      entry_in.ovf = ({LowBits'(0), dist_mag} >= {focal, LowBits'(0)});
   end

   // Resolve one bit per stage
   always_comb begin
      for (int j = 0; j < DivSteps; j++) begin
         step_in[j] = div_step(stage_ff[j], focal);
      end
   end

   // Apply sign and saturate to the Q3.20 range
   always_comb begin
      if (stage_ff[DivSteps].neg) begin
         if (stage_ff[DivSteps].ovf || (stage_ff[DivSteps].quo > NormNegMin)) begin
            norm_in = NormNegMin;
         end else begin
            norm_in = -stage_ff[DivSteps].quo;
         end
      end else begin
         if (stage_ff[DivSteps].ovf || (stage_ff[DivSteps].quo > NormPosMax)) begin
            norm_in = NormPosMax;
         end else begin
            norm_in = stage_ff[DivSteps].quo;
         end
      end
   end

   // Advance the divider pipeline
   always_ff @(posedge clock) begin
      stage_ff[0] <= entry_in;
      for (int j = 0; j < DivSteps; j++) begin
         stage_ff[j+1] <= step_in[j];
      end
      norm_ff <= norm_in;
   end

   assign norm = $signed(norm_ff);

endmodule

// File: tb/rud_checker.sv
// Checker for the radial undistortion point map: predicts each source coordinate and compares.
`timescale 1ns / 100ps

module rud_checker import rud_pkg::*; #(
   parameter int IMG_WIDTH  = ImgWidthDefault,
   parameter int IMG_HEIGHT = ImgHeightDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  rud_req_type         req_data,
   input  logic                rsp_valid,
   input  rud_rsp_type         rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic                pready,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output int                  pending_count,
   output int                  mismatch_count
);

   localparam longint Q20One    = 64'sd1 << FracW;
   localparam longint NormHi    = (64'sd1 << (NormW - 1)) - 1;
   localparam longint NormLo    = -(64'sd1 << (NormW - 1));
   localparam longint PowHi     = (64'sd1 << PowW) - 1;
   localparam longint ScaledLim = 64'sd1 << ScaledLimLog2;

   // Shadow copy of the lens registers
   logic [CoordW-1:0]        focal_x, focal_y, ctr_col, ctr_row;
   logic signed [CoefW-1:0]  coef_k1, coef_k2, coef_k3;

   rud_rsp_type expected_sources[$];
   rud_rsp_type want;
   logic [CsrIdxW-1:0] csr_index;

   function automatic longint clamp64(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Offset by the center and divide by the focal length, truncating toward zero
   function automatic longint normalize_coord(logic [PixW-1:0] pix, logic [CoordW-1:0] center,
                                              logic [CoordW-1:0] focal);
      longint offset;
      longint divisor;
      offset  = longint'({pix, {PixFracW{1'b0}}}) - longint'(center);
      divisor = (focal == '0) ? 64'sd1 : longint'(focal);
      return clamp64((offset * Q20One) / divisor, NormLo, NormHi);
   endfunction

   // Apply the gain, return to pixel units and clamp to the image
   function automatic logic [CoordW-1:0] pixel_from_norm(longint norm, longint gain,
         logic [CoordW-1:0] focal, logic [CoordW-1:0] center, int img);
      longint divisor;
      longint scaled;
      longint pos;
      divisor = (focal == '0) ? 64'sd1 : longint'(focal);
      scaled  = clamp64((norm * gain) >>> FracW, -ScaledLim, ScaledLim);
      pos     = ((scaled * divisor) >>> FracW) + longint'(center);
      pos     = clamp64(pos, 64'sd0, longint'(img - 1) * 256);
      return pos[CoordW-1:0];
   endfunction

   function automatic rud_rsp_type map_source_point(rud_req_type px);
      longint nx, ny, r2, r4, r6, poly, gain;
      rud_rsp_type res;
      nx = normalize_coord(px.pixel_col, ctr_col, focal_x);
      ny = normalize_coord(px.pixel_row, ctr_row, focal_y);
      r2 = (nx * nx + ny * ny) >>> FracW;
      r4 = (r2 * r2) >>> FracW;
      if (r4 > PowHi) r4 = PowHi;
      r6 = (r4 * r2) >>> FracW;
      if (r6 > PowHi) r6 = PowHi;
      poly = longint'(coef_k1) * r2 + longint'(coef_k2) * r4 + longint'(coef_k3) * r6;
      gain = Q20One + (poly >>> FracW);
      res.source_col = pixel_from_norm(nx, gain, focal_x, ctr_col, IMG_WIDTH);
      res.source_row = pixel_from_norm(ny, gain, focal_y, ctr_row, IMG_HEIGHT);
      return res;
   endfunction

   initial begin
      pending_count  = 0;
      mismatch_count = 0;
   end

   assign csr_index = paddr[CsrAddrW-1:2];

   // Track register writes, predict accepted transactions, check results
   always @(posedge clock) begin
      if (reset) begin
         focal_x  = FocalReset;
         focal_y  = FocalReset;
         ctr_col  = CenterXReset;
         ctr_row  = CenterYReset;
         coef_k1  = '0;
         coef_k2  = '0;
         coef_k3  = '0;
         expected_sources.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index)
               RegFocalX:   focal_x  = pwdata[CoordW-1:0];
               RegFocalY:   focal_y  = pwdata[CoordW-1:0];
               RegCenterX:  ctr_col  = pwdata[CoordW-1:0];
               RegCenterY:  ctr_row  = pwdata[CoordW-1:0];
               RegRadialK1: coef_k1  = pwdata[CoefW-1:0];
               RegRadialK2: coef_k2  = pwdata[CoefW-1:0];
               RegRadialK3: coef_k3  = pwdata[CoefW-1:0];
               default: ;
            endcase
         end
         if (start && !busy)
            expected_sources.push_back(map_source_point(req_data));
         if (rsp_valid) begin
            if (expected_sources.size() == 0) begin
               $error("unexpected result: source_col %0d source_row %0d",
                      rsp_data.source_col, rsp_data.source_row);
               mismatch_count++;
            end else begin
               want = expected_sources.pop_front();
               if (rsp_data.source_col !== want.source_col) begin
                  $error("source_col: expected %0d, actual %0d",
                         want.source_col, rsp_data.source_col);
                  mismatch_count++;
               end
               if (rsp_data.source_row !== want.source_row) begin
                  $error("source_row: expected %0d, actual %0d",
                         want.source_row, rsp_data.source_row);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = expected_sources.size();
   end

endmodule

// File: tb/tb_top.sv
// Top of the radial undistortion point map testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top import rud_pkg::*; ();

   localparam int ImgW        = 640;
   localparam int ImgH        = 480;
   localparam int PhaseCount  = 8;
   localparam int ItemsPerPhase = 240;
   localparam int DrainCycles = 60;
   localparam int CycleLimit  = 300000;
   localparam logic [CsrIdxW-1:0] RegUnused = 3'd7;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   rud_req_type         req_data = '0;
   logic                rsp_valid;
   rud_rsp_type         rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CsrAddrW-1:0] paddr = '0;
   logic [CsrDataW-1:0] pwdata = '0;
   logic [CsrDataW-1:0] prdata;
   logic                pready;
   int                  pending_count;
   int                  mismatch_count;
   int                  cycle_count = 0;

   always #2 clock = ~clock;

   radial_undistortion_point_map #(
      .IMG_WIDTH  (ImgW),
      .IMG_HEIGHT (ImgH)
   ) dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   rud_checker #(
      .IMG_WIDTH  (ImgW),
      .IMG_HEIGHT (ImgH)
   ) checker_i (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .pending_count, .mismatch_count
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Write one register; bits above its width carry random junk
   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] value);
      logic [CsrDataW-1:0] keep;
      keep = (idx >= RegRadialK1) ? {{(CsrDataW-CoefW){1'b0}}, {CoefW{1'b1}}}
                                  : {{(CsrDataW-CoordW){1'b0}}, {CoordW{1'b1}}};
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= (value & keep) | ($urandom() & ~keep);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_lens(int fx, int fy, int cx, int cy, int k1, int k2, int k3);
      csr_write(RegFocalX, fx);
      csr_write(RegFocalY, fy);
      csr_write(RegCenterX, cx);
      csr_write(RegCenterY, cy);
      csr_write(RegRadialK1, k1);
      csr_write(RegRadialK2, k2);
      csr_write(RegRadialK3, k3);
   endtask

   // Present one transaction and hold it until accepted
   task automatic drive_item(rud_req_type item);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Drop start and hold off until every result is back
   task automatic drain();
      idle_cycles(1);
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic rud_req_type rand_pixel();
      rud_req_type px;
      case ($urandom_range(0, 9))
         0, 1: begin
            px.pixel_col = PixW'($urandom_range(0, 4095));
            px.pixel_row = PixW'($urandom_range(0, 4095));
         end
         2: begin
            px.pixel_col = PixW'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                      : $urandom_range(ImgW - 4, ImgW - 1));
            px.pixel_row = PixW'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                      : $urandom_range(ImgH - 4, ImgH - 1));
         end
         default: begin
            px.pixel_col = PixW'($urandom_range(0, ImgW - 1));
            px.pixel_row = PixW'($urandom_range(0, ImgH - 1));
         end
      endcase
      return px;
   endfunction

   // Corners, center and bit patterns of the pixel fields
   task automatic run_directed();
      drive_item('{pixel_col: 12'd0,    pixel_row: 12'd0});
      drive_item('{pixel_col: 12'd4095, pixel_row: 12'd4095});
      drive_item('{pixel_col: 12'd0,    pixel_row: 12'd4095});
      drive_item('{pixel_col: 12'd4095, pixel_row: 12'd0});
      drive_item('{pixel_col: 12'd320,  pixel_row: 12'd240});
      drive_item('{pixel_col: 12'd639,  pixel_row: 12'd479});
      drive_item('{pixel_col: 12'd640,  pixel_row: 12'd480});
      drive_item('{pixel_col: 12'd1,    pixel_row: 12'd1});
      drive_item('{pixel_col: 12'hAAA,  pixel_row: 12'h555});
      drive_item('{pixel_col: 12'h555,  pixel_row: 12'hAAA});
      drive_item('{pixel_col: 12'd2048, pixel_row: 12'd2048});
      drive_item('{pixel_col: 12'd0,    pixel_row: 12'd240});
   endtask

   // Random transactions in bursts with random gaps, some stretches back to back
   task automatic run_random(int n);
      int left;
      int burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left) burst = left;
         repeat (burst) drive_item(rand_pixel());
         left -= burst;
         idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
   endtask

   task automatic load_setting(int phase);
      case (phase)
         // barrel distortion
         1: load_lens(128000, 122880, 81920, 61440, -209715, 52429, 0);
         // pincushion with a higher-order term
         2: load_lens(153600, 153600, 80000, 62000, 314573, -104858, 20972);
         // tiny focal, largest coefficients: saturation throughout
         3: load_lens(1, 1, 0, 0, 8388607, 8388607, 8388607);
         // largest focal and center, most negative coefficients
         4: load_lens(1048575, 1048575, 1048575, 1048575, -8388608, -8388608, -8388608);
         // zero focal lengths stand for the smallest step
         5: load_lens(0, 0, $urandom_range(0, 163840), $urandom_range(0, 122880),
                      $urandom_range(0, 1048575) - 524288, $urandom_range(0, 1048575) - 524288,
                      $urandom_range(0, 1048575) - 524288);
         // every register over its full range
         6: load_lens($urandom_range(0, 1048575), $urandom_range(0, 1048575),
                      $urandom_range(0, 1048575), $urandom_range(0, 1048575),
                      $urandom(), $urandom(), $urandom());
         // plausible lens, then a write to an unmapped register
         default: begin
            load_lens($urandom_range(200, 2000) * 256, $urandom_range(200, 2000) * 256,
                      $urandom_range(60000, 100000), $urandom_range(40000, 80000),
                      $urandom_range(0, 1048576) - 524288, $urandom_range(0, 262144) - 131072,
                      $urandom_range(0, 65536) - 32768);
            csr_write(RegUnused, $urandom());
         end
      endcase
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Reset settings first, then each lens setting once idle
      for (int phase = 0; phase < PhaseCount; phase++) begin
         if (phase != 0) load_setting(phase);
         if (phase == 0 || phase == 3) run_directed();
         run_random(ItemsPerPhase);
         drain();
      end

      // Let any straggling result surface
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
